@@ rtl/core/trs_pkg.sv @@
// ============================================================================
// trs_pkg - shared types, constants and helpers for the TRS matrix builder
// Fixed-point formats, the CORDIC arctangent table and the Q2.30 multiply.
// ============================================================================
package trs_pkg;

    localparam int FRAC_BITS = 16;

    // Sine/cosine and rotation entries are Q2.30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // elem_3 of the translation column
    localparam logic [31:0] ONE_FIX = 32'(64'd1 << FRAC_BITS);

    // Register stages ahead of the first CORDIC iteration, and after the last
    localparam int SC_PRE  = 6;
    localparam int SC_POST = 1;
    localparam int ROT_LAT = 3;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // atan(2^-i) in phase units, 2^32 per full turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Q2.30 product, rounded half up
    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

@@ rtl/core/trs_sincos.sv @@
// ============================================================================
// trs_sincos - pipelined degree-to-phase conversion and CORDIC sine/cosine
// One register stage per CORDIC iteration; advances on the shared enable.
// ============================================================================
module trs_sincos import trs_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               advance,
    input  logic signed [25:0] angle,
    output logic signed [31:0] cos_o,
    output logic signed [31:0] sin_o
);

    localparam logic [25:0] RECIP_A = 26'd47721859;  // ceil(2^31 / 45)
    localparam logic [19:0] RECIP_B = 20'd745655;    // ceil(2^25 / 45)

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        quad_t              q;
    } cord_t;

    logic [25:0] mag1_reg, mag2_reg;
    logic        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [19:0] a2_reg, a3_reg, a4_reg;
    logic [5:0]  b3_reg;
    logic [12:0] q4_reg;
    logic [31:0] phase5_reg;
    cord_t       start_reg;
    cord_t       cord_reg [CORDIC_STAGES];
    logic signed [31:0] cos_reg, sin_reg;

    logic [51:0] prod_a;
    logic [18:0] vb;
    logic [38:0] prod_b;
    logic [31:0] ph_mag;
    logic [31:0] ph_turn;
    logic [1:0]  quad_c;

    always_comb begin
        prod_a  = 52'(mag1_reg) * 52'(RECIP_A);
        vb      = {b3_reg, 13'b0} + 19'd22;
        prod_b  = 39'(vb) * 39'(RECIP_B);
        ph_mag  = {a4_reg[18:0], 13'b0} + 32'(q4_reg);
        ph_turn = phase5_reg + 32'h2000_0000;
        quad_c  = ph_turn[31:30];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mag1_reg   <= angle[25] ? 26'(-angle) : 26'(angle);
            neg1_reg   <= angle[25];
            a2_reg     <= prod_a[50:31];
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            b3_reg     <= 6'(mag2_reg - 26'(a2_reg) * 26'd45);
            a3_reg     <= a2_reg;
            neg3_reg   <= neg2_reg;
            q4_reg     <= prod_b[37:25];
            a4_reg     <= a3_reg;
            neg4_reg   <= neg3_reg;
            phase5_reg <= neg4_reg ? -ph_mag : ph_mag;
            start_reg.x <= GAIN_Q30;
            start_reg.y <= 32'sd0;
            start_reg.z <= $signed(phase5_reg - {quad_c, 30'b0});
            start_reg.q <= quad_t'(quad_c);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        cord_t src;
        logic signed [31:0] dx, dy;
        assign src = (i == 0) ? start_reg : cord_reg[(i == 0) ? 0 : i - 1];
        assign dx  = src.y >>> i;
        assign dy  = src.x >>> i;
        always_ff @(posedge aclk) begin
            if (advance) begin
                cord_reg[i].q <= src.q;
                if (!src.z[31]) begin
                    cord_reg[i].x <= src.x - dx;
                    cord_reg[i].y <= src.y + dy;
                    cord_reg[i].z <= src.z - $signed(atan_turn(i));
                end else begin
                    cord_reg[i].x <= src.x + dx;
                    cord_reg[i].y <= src.y - dy;
                    cord_reg[i].z <= src.z + $signed(atan_turn(i));
                end
            end
        end
    end

    // Fold the quadrant back in
    always_ff @(posedge aclk) begin
        if (advance) begin
            case (cord_reg[CORDIC_STAGES-1].q)
                QUAD_0: begin
                    cos_reg <= cord_reg[CORDIC_STAGES-1].x;
                    sin_reg <= cord_reg[CORDIC_STAGES-1].y;
                end
                QUAD_1: begin
                    cos_reg <= -cord_reg[CORDIC_STAGES-1].y;
                    sin_reg <= cord_reg[CORDIC_STAGES-1].x;
                end
                QUAD_2: begin
                    cos_reg <= -cord_reg[CORDIC_STAGES-1].x;
                    sin_reg <= -cord_reg[CORDIC_STAGES-1].y;
                end
                default: begin
                    cos_reg <= cord_reg[CORDIC_STAGES-1].y;
                    sin_reg <= -cord_reg[CORDIC_STAGES-1].x;
                end
            endcase
        end
    end

    assign cos_o = cos_reg;
    assign sin_o = sin_reg;

endmodule

@@ rtl/core/trs_rotmat.sv @@
// ============================================================================
// trs_rotmat - three-stage build of R = Rx * Ry * Rz in Q2.30
// Entries leave row-major, index row*3 + column, sign-extended to 34 bits.
// ============================================================================
module trs_rotmat import trs_pkg::*; (
    input  logic               aclk,
    input  logic               advance,
    input  logic signed [31:0] cx,
    input  logic signed [31:0] sx,
    input  logic signed [31:0] cy,
    input  logic signed [31:0] sy,
    input  logic signed [31:0] cz,
    input  logic signed [31:0] sz,
    output logic signed [33:0] r_o [9]
);

    logic signed [31:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sxcy_reg, cxcy_reg;
    logic signed [31:0] cxsz_reg, cxcz_reg, sxsz_reg, sxcz_reg, sy1_reg, cz1_reg, sz1_reg;
    logic signed [31:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [31:0] cycz2_reg, cysz2_reg, sxcy2_reg, cxcy2_reg, sy2_reg;
    logic signed [31:0] cxsz2_reg, cxcz2_reg, sxsz2_reg, sxcz2_reg;
    logic signed [33:0] r_reg [9];

    always_ff @(posedge aclk) begin
        if (advance) begin
            sxsy_reg <= mul30(sx, sy);
            cxsy_reg <= mul30(cx, sy);
            cycz_reg <= mul30(cy, cz);
            cysz_reg <= mul30(cy, sz);
            sxcy_reg <= mul30(sx, cy);
            cxcy_reg <= mul30(cx, cy);
            cxsz_reg <= mul30(cx, sz);
            cxcz_reg <= mul30(cx, cz);
            sxsz_reg <= mul30(sx, sz);
            sxcz_reg <= mul30(sx, cz);
            sy1_reg  <= sy;
            cz1_reg  <= cz;
            sz1_reg  <= sz;

            m1_reg    <= mul30(sxsy_reg, cz1_reg);
            m2_reg    <= mul30(sxsy_reg, sz1_reg);
            m3_reg    <= mul30(cxsy_reg, cz1_reg);
            m4_reg    <= mul30(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            sxcy2_reg <= sxcy_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg   <= sy1_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;

            r_reg[0] <= 34'(cycz2_reg);
            r_reg[1] <= -34'(cysz2_reg);
            r_reg[2] <= 34'(sy2_reg);
            r_reg[3] <= 34'(m1_reg) + 34'(cxsz2_reg);
            r_reg[4] <= 34'(cxcz2_reg) - 34'(m2_reg);
            r_reg[5] <= -34'(sxcy2_reg);
            r_reg[6] <= 34'(sxsz2_reg) - 34'(m3_reg);
            r_reg[7] <= 34'(m4_reg) + 34'(sxcz2_reg);
            r_reg[8] <= 34'(cxcy2_reg);
        end
    end

    assign r_o = r_reg;

endmodule

@@ rtl/core/trs_model_matrix_builder_top.sv @@
// ============================================================================
// trs_model_matrix_builder_top - T*Rx*Ry*Rz*S model matrix, one column a beat
// Converts three Euler angles to sine/cosine by CORDIC, forms the rotation,
// scales it per column and sends the four matrix columns on the m_ side.
// ============================================================================
//
//  channel | dir | tdata fields (lowest bit up)                       | tlast
//  --------+-----+----------------------------------------------------+------------
//  s_      | in  | pos_x,pos_y,pos_z,angle_x..z,scale_x..z (270 of 272)| -
//  m_      | out | column_index, elem_0..elem_3 (130 of 136)          | last_column
//
//  A transform yields four beats, one column per cycle while m_tready is high, so
//  the single output port limits how often the block takes a new transform.
//  An s_ beat reaches m_ via the sine/cosine, rotation, scale and output registers.
//  Every stage advances together on one enable, which is high when the output
//  register is empty or is handing over its last column; s_tready is that enable.
//  A stall on m_ freezes every stage and valid bit in place, nothing is lost.
//  Reset (aresetn low, synchronous) clears only the valid bits and column count.
// ============================================================================
module trs_model_matrix_builder_top import trs_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0] pos_y[63:32] pos_z[95:64] angle_x[121:96] angle_y[147:122]
    // angle_z[173:148] scale_x[205:174] scale_y[237:206] scale_z[269:238]
    input  logic [271:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // column_index[1:0] elem_0[33:2] elem_1[65:34] elem_2[97:66] elem_3[129:98]
    output logic [135:0] m_tdata,
    output logic         m_tlast
);

    localparam int SIDE_DEPTH = SC_PRE + CORDIC_STAGES + SC_POST + ROT_LAT;
    localparam logic [1:0] COL_LAST = 2'd3;

    // Sideband travelling beside the angle datapath
    typedef struct packed {
        logic        valid;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
    } side_t;

    side_t side_reg [SIDE_DEPTH];
    side_t side_in;
    side_t side_out;

    logic advance;
    logic signed [31:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
    logic signed [33:0] rot [9];

    logic signed [65:0] prod_reg [9];
    logic        s1_valid_reg, s2_valid_reg;
    logic [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [31:0] s2_px_reg, s2_py_reg, s2_pz_reg;
    logic [31:0] sat_reg [9];

    logic        out_valid_reg;
    logic [1:0]  col_reg;
    logic [31:0] out_elem_reg [9];
    logic [31:0] out_px_reg, out_py_reg, out_pz_reg;
    logic [31:0] e0, e1, e2, e3;

    // Round a Q2.30 * Q16.16 product back to Q16.16 and clamp
    function automatic logic [31:0] round_sat(input logic signed [65:0] p);
        logic signed [65:0] t;
        logic signed [35:0] s;
        t = p + 66'sd536870912;
        s = t[65:30];
        if (s > $signed(36'h07FFFFFFF)) begin
            return 32'h7FFF_FFFF;
        end else if (s < $signed(36'hF80000000)) begin
            return 32'h8000_0000;
        end
        return s[31:0];
    endfunction

    assign advance = !out_valid_reg || (m_tready && (col_reg == COL_LAST));
    assign s_tready = advance;

    assign side_in.valid = s_tvalid;
    assign side_in.px    = s_tdata[31:0];
    assign side_in.py    = s_tdata[63:32];
    assign side_in.pz    = s_tdata[95:64];
    assign side_in.kx    = s_tdata[205:174];
    assign side_in.ky    = s_tdata[237:206];
    assign side_in.kz    = s_tdata[269:238];
    assign side_out      = side_reg[SIDE_DEPTH-1];

    // Shift the sideband; only the valid bit takes the reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDE_DEPTH; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (advance) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < SIDE_DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    trs_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_x (
        .aclk(aclk), .advance(advance), .angle($signed(s_tdata[121:96])),
        .cos_o(cos_x), .sin_o(sin_x)
    );
    trs_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_y (
        .aclk(aclk), .advance(advance), .angle($signed(s_tdata[147:122])),
        .cos_o(cos_y), .sin_o(sin_y)
    );
    trs_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_z (
        .aclk(aclk), .advance(advance), .angle($signed(s_tdata[173:148])),
        .cos_o(cos_z), .sin_o(sin_z)
    );

    trs_rotmat u_rot (
        .aclk(aclk), .advance(advance),
        .cx(cos_x), .sx(sin_x), .cy(cos_y), .sy(sin_y), .cz(cos_z), .sz(sin_z),
        .r_o(rot)
    );

    // Scale stage: column k of R times scale k, then round and clamp
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int j = 0; j < 9; j += 3) begin
                prod_reg[j]   <= rot[j]   * $signed(side_out.kx);
                prod_reg[j+1] <= rot[j+1] * $signed(side_out.ky);
                prod_reg[j+2] <= rot[j+2] * $signed(side_out.kz);
            end
            s1_px_reg <= side_out.px;
            s1_py_reg <= side_out.py;
            s1_pz_reg <= side_out.pz;
            for (int j = 0; j < 9; j++) begin
                sat_reg[j] <= round_sat(prod_reg[j]);
            end
            s2_px_reg <= s1_px_reg;
            s2_py_reg <= s1_py_reg;
            s2_pz_reg <= s1_pz_reg;
            out_elem_reg <= sat_reg;
            out_px_reg   <= s2_px_reg;
            out_py_reg   <= s2_py_reg;
            out_pz_reg   <= s2_pz_reg;
        end
    end

    // Valid bits of the scale stages and the output register; column count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= 2'd0;
        end else begin
            if (advance) begin
                s1_valid_reg  <= side_out.valid;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
            if (out_valid_reg && m_tready) begin
                col_reg <= col_reg + 2'd1;
            end
        end
    end

    // Pick the column on show; elem_n is row n of the column
    always_comb begin
        case (col_reg)
            2'd0: begin
                e0 = out_elem_reg[0]; e1 = out_elem_reg[3]; e2 = out_elem_reg[6];
                e3 = 32'd0;
            end
            2'd1: begin
                e0 = out_elem_reg[1]; e1 = out_elem_reg[4]; e2 = out_elem_reg[7];
                e3 = 32'd0;
            end
            2'd2: begin
                e0 = out_elem_reg[2]; e1 = out_elem_reg[5]; e2 = out_elem_reg[8];
                e3 = 32'd0;
            end
            default: begin
                e0 = out_px_reg; e1 = out_py_reg; e2 = out_pz_reg;
                e3 = ONE_FIX;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = (col_reg == COL_LAST);
    assign m_tdata  = {6'd0, e3, e2, e1, e0, col_reg};

    // Columns leave in order, one after another
    a_col_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1))
        else $error("column order broken");

    // Row 3 is zero on the rotation columns
    a_row3_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[129:98] == 32'd0))
        else $error("row 3 nonzero on a rotation column");

    // With the output register empty the pipeline must flow
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input held off while output empty");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Model matrix builder testbench
// Drives transforms on the s_ stream, predicts the four matrix columns with a
// CORDIC-based model of its own and checks every m_ beat in order.
// ----------------------------------------------------------------------------
module tb_top import trs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;

    typedef struct packed {
        logic [1:0]  col;
        logic [31:0] e0, e1, e2, e3;
        logic        last;
    } column_t;

    // Angle turn table, atan(2^-i) with 2^32 per turn
    function automatic longint turn_step(input int i);
        longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1};
        return t[i];
    endfunction

    function automatic longint fdiv(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint rnd30(input longint v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // Degrees (Q10.16) to cos/sin in Q2.30
    function automatic void angle_sincos(input logic [25:0] raw, output longint c,
                                         output longint s);
        longint a, x, y, z, dx, dy;
        logic [63:0] mag, dv, ph;
        logic [31:0] phase, u;
        logic [1:0] q;
        a = longint'(signed'(raw));
        mag = (a < 0) ? -a : a;
        dv = 64'd360 << FRAC_BITS;
        ph = ((mag << 32) + dv / 2) / dv;
        if (a < 0) ph = -ph;
        phase = ph[31:0];
        q = 2'((phase + 32'h20000000) >> 30);
        u = phase - (32'(q) << 30);
        z = longint'(signed'(u));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STAGES && i < 30; i++) begin
            dx = fdiv(y, i);
            dy = fdiv(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z -= turn_step(i);
            end else begin
                x = x + dx; y = y - dy; z += turn_step(i);
            end
        end
        case (quad_t'(q))
            QUAD_0: begin c = x;  s = y;  end
            QUAD_1: begin c = -y; s = x;  end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    int fail_count = 0;

    function automatic void report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        fail_count++;
    endfunction

    class column_board;
        column_t pending[$];
        int      checked;

        function void note_transform(input logic [271:0] d);
            longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
            longint r[3][3];
            longint scl;
            column_t c;
            angle_sincos(d[121:96], cx, sx);
            angle_sincos(d[147:122], cy, sy);
            angle_sincos(d[173:148], cz, sz);
            sxsy = rnd30(sx * sy);
            cxsy = rnd30(cx * sy);
            r[0][0] = rnd30(cy * cz);
            r[0][1] = -rnd30(cy * sz);
            r[0][2] = sy;
            r[1][0] = rnd30(sxsy * cz) + rnd30(cx * sz);
            r[1][1] = -rnd30(sxsy * sz) + rnd30(cx * cz);
            r[1][2] = -rnd30(sx * cy);
            r[2][0] = -rnd30(cxsy * cz) + rnd30(sx * sz);
            r[2][1] = rnd30(cxsy * sz) + rnd30(sx * cz);
            r[2][2] = rnd30(cx * cy);
            for (int k = 0; k < 3; k++) begin
                scl = longint'(signed'(d[174 + 32*k +: 32]));
                c.col = 2'(k);
                c.e0 = clip32(rnd30(r[0][k] * scl));
                c.e1 = clip32(rnd30(r[1][k] * scl));
                c.e2 = clip32(rnd30(r[2][k] * scl));
                c.e3 = '0;
                c.last = 1'b0;
                pending.push_back(c);
            end
            c = '{2'd3, d[31:0], d[63:32], d[95:64], ONE_FIX, 1'b1};
            pending.push_back(c);
        endfunction

        function void check_column(input logic [135:0] d, input logic l);
            column_t w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected column beat %h", d));
                return;
            end
            w = pending.pop_front();
            checked++;
            if (d[1:0] !== w.col)
                report($sformatf("column_index %0d exp %0d", d[1:0], w.col));
            if (d[33:2] !== w.e0)
                report($sformatf("col %0d elem_0 %h exp %h", w.col, d[33:2], w.e0));
            if (d[65:34] !== w.e1)
                report($sformatf("col %0d elem_1 %h exp %h", w.col, d[65:34], w.e1));
            if (d[97:66] !== w.e2)
                report($sformatf("col %0d elem_2 %h exp %h", w.col, d[97:66], w.e2));
            if (d[129:98] !== w.e3)
                report($sformatf("col %0d elem_3 %h exp %h", w.col, d[129:98], w.e3));
            if (l !== w.last)
                report($sformatf("col %0d last_column %b exp %b", w.col, l, w.last));
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [271:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tlast;

    column_board board = new();
    longint      cycles = 0;
    int          sent = 0;
    bit          quiet = 1'b0;     // long stretch with no idling on either side

    trs_model_matrix_builder_top #(.CORDIC_STAGES(STAGES)) i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hold the run to a generous cycle budget
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("timeout after %0d cycles", cycles);
            $display("trs_model_matrix_builder_top verification failed");
            $finish;
        end
    end

    // Note accepted transforms and check returned columns on the same edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_transform(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_column(m_tdata, m_tlast);
    end

    // Receiver: stall in roughly a quarter of cycles, unless in the quiet stretch
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= quiet || ($urandom_range(99) >= 25);
    end

    function automatic logic [25:0] rand_angle(input int mode);
        int v;
        case (mode)
            0: v = $urandom_range(47185920) - 23592960;
            1: v = ($urandom_range(8) - 4) * 5898240;        // quarter turns
            2: v = ($urandom_range(16) - 8) * 2949120        // near octants
                   + $urandom_range(4) - 2;
            default: v = $urandom_range(2621440) - 1310720;  // within 20 degrees
        endcase
        return v[25:0];
    endfunction

    function automatic logic [31:0] rand_word(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(262144) - 131072;       // within +-2.0
            2: return (($urandom_range(1)) ? 32'h7fffffff : 32'h80000000)
                      ^ $urandom_range(3);
            default: return 32'h00010000;
        endcase
    endfunction

    // Send one transform, optionally idling first
    task automatic send_transform(input logic [271:0] d);
        while (!quiet && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_fields(input logic [31:0] px, py, pz,
                               input logic [25:0] ax, ay, az,
                               input logic [31:0] kx, ky, kz);
        send_transform({2'b00, kz, ky, kx, az, ay, ax, pz, py, px});
    endtask

    initial begin
        int m;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: identity, field extremes, quadrants, wrap beyond one turn
        send_fields(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
        send_fields(32'h7fffffff, 32'h80000000, 32'hffffffff,
                    26'd23592960, -26'sd23592960, 26'd0,
                    32'h7fffffff, 32'h80000000, 32'h00000001);
        send_fields(32'h80000000, 32'h7fffffff, 0,
                    26'h1ffffff, 26'h2000000, 26'h3ffffff,
                    32'h80000000, 32'h7fffffff, 32'hffffffff);
        for (int k = -4; k <= 4; k++)
            send_fields(k, -k, 0, 26'(k * 5898240), 26'(-k * 5898240),
                        26'(k * 2949120), 32'h10000, 32'hfffe0000, 32'h7fffffff);
        send_fields(1, 2, 3, 26'd2949120, 26'd2949119, -26'sd2949120,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_fields(0, 0, 0, 26'h2000000, 26'h1ffffff, 26'd1,
                    32'h80000000, 32'h80000000, 32'h80000000);
        send_fields(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f,
                    26'h1555555, 26'h2aaaaaa, 26'h0f0f0f0,
                    32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0);

        // Random transforms, with a quiet stretch part way through
        for (int n = 0; n < 355; n++) begin
            quiet = (n >= 120 && n < 180);
            m = $urandom_range(3);
            send_fields(rand_word($urandom_range(2)), rand_word($urandom_range(2)),
                        rand_word($urandom_range(2)),
                        rand_angle($urandom_range(3)), rand_angle($urandom_range(3)),
                        rand_angle($urandom_range(3)),
                        rand_word(m), rand_word($urandom_range(3)),
                        rand_word($urandom_range(3)));
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        // Drain the pipeline, then idle on so that any stray column beat is caught
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (STAGES + 40) @(posedge aclk);

        $display("covered %0d transforms, %0d column beats checked",
                 sent, board.checked);
        if (fail_count == 0) begin
            $display("trs_model_matrix_builder_top verification clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("trs_model_matrix_builder_top verification failed");
        end
        $finish;
    end
endmodule
